>>> rtl/core/spq_pkg.sv
package spq_pkg;

	localparam int CAPACITY_DEF   = 64;
	localparam int STAMP_BITS_DEF = 32;

	localparam int VAL_W = 32;
	localparam int PRI_W = 32;
	localparam int OP_W  = 2;
	localparam int ST_W  = 2;

	localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
	localparam logic [OP_W-1:0] OP_EXTRACT = 2'd1;
	localparam logic [OP_W-1:0] OP_PEEK    = 2'd2;
	localparam logic [OP_W-1:0] OP_CHANGE  = 2'd3;

	localparam logic [ST_W-1:0] STS_OK        = 2'd0;
	localparam logic [ST_W-1:0] STS_EMPTY     = 2'd1;
	localparam logic [ST_W-1:0] STS_FULL      = 2'd2;
	localparam logic [ST_W-1:0] STS_NOT_FOUND = 2'd3;

	// per-cell command: ins places the broadcast entry, shifting lower-ranked cells right; pull takes the right neighbour
	typedef struct packed {
		logic ins;
		logic pull;
	} cell_cmd_t;

endpackage

>>> rtl/core/stable_priority_queue.sv
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | opcode, item_value, item_priority
// out     | output    | out_valid / out_ready| status, head_value, entry_count
//
// insert places the item with one broadcast compare across the cell row; extract and peek read the head cell
// a priority change removes the first matching entry, then re-places it in the ST_PLACE state
// a new item is taken when no re-place step is pending and the result register is empty or being emptied
// reset clears the entry count and the stamp counter; entry cells are not cleared
// out_ready low holds the result and stalls the input side
module stable_priority_queue #(
	parameter int CAPACITY   = spq_pkg::CAPACITY_DEF,
	parameter int STAMP_BITS = spq_pkg::STAMP_BITS_DEF,
	localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic        [spq_pkg::OP_W-1:0]  opcode,
	input  logic signed [spq_pkg::VAL_W-1:0] item_value,
	input  logic signed [spq_pkg::PRI_W-1:0] item_priority,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic        [spq_pkg::ST_W-1:0]  status,
	output logic signed [spq_pkg::VAL_W-1:0] head_value,
	output logic        [CNT_W-1:0]          entry_count
);
	import spq_pkg::*;

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_PLACE = 1'b1;

	logic                    state_q, state_d;
	logic [CNT_W-1:0]        count_q, count_d;
	logic [STAMP_BITS-1:0]   arrival_q, arrival_d;
	logic [VAL_W-1:0]        hold_val_q;
	logic signed [PRI_W-1:0] hold_pri_q;
	logic [STAMP_BITS-1:0]   hold_stamp_q;
	logic                    hold_load;

	logic                    out_valid_q;
	logic [ST_W-1:0]         status_q;
	logic [VAL_W-1:0]        head_q;
	logic [CNT_W-1:0]        cnt_out_q;
	logic                    res_load;
	logic [ST_W-1:0]         res_status;
	logic [VAL_W-1:0]        res_head;

	logic                    accept;
	logic                    ins_all, pull_all, pull_some;

	logic [VAL_W-1:0]        new_val;
	logic signed [PRI_W-1:0] new_pri;
	logic [STAMP_BITS-1:0]   new_stamp;

	logic [VAL_W-1:0]        c_val   [CAPACITY];
	logic signed [PRI_W-1:0] c_pri   [CAPACITY];
	logic [STAMP_BITS-1:0]   c_stamp [CAPACITY];
	logic [CAPACITY-1:0]     c_gt, c_match, c_valid;

	logic                    found;
	logic [CAPACITY-1:0]     from_first;
	logic [STAMP_BITS-1:0]   first_stamp;

	logic                    is_empty, is_full;

	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CNT_W'(CAPACITY));

	always_comb begin
		if (state_q == ST_PLACE) begin
			new_val   = hold_val_q;
			new_pri   = hold_pri_q;
			new_stamp = hold_stamp_q;
		end else begin
			new_val   = item_value;
			new_pri   = item_priority;
			new_stamp = arrival_q;
		end
	end

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		arrival_d  = arrival_q;
		ins_all    = 1'b0;
		pull_all   = 1'b0;
		pull_some  = 1'b0;
		hold_load  = 1'b0;
		res_load   = 1'b0;
		res_status = STS_OK;
		res_head   = '0;
		if (state_q == ST_PLACE) begin
			ins_all  = 1'b1;
			count_d  = count_q + 1'b1;
			res_load = 1'b1;
			state_d  = ST_IDLE;
		end else if (accept) begin
			case (opcode)
				OP_INSERT: begin
					res_load = 1'b1;
					if (is_full) begin
						res_status = STS_FULL;
					end else begin
						ins_all   = 1'b1;
						count_d   = count_q + 1'b1;
						arrival_d = arrival_q + 1'b1;
					end
				end
				OP_EXTRACT: begin
					res_load = 1'b1;
					if (is_empty) begin
						res_status = STS_EMPTY;
					end else begin
						res_head = c_val[0];
						pull_all = 1'b1;
						count_d  = count_q - 1'b1;
					end
				end
				OP_PEEK: begin
					res_load = 1'b1;
					if (is_empty) begin
						res_status = STS_EMPTY;
					end else begin
						res_head = c_val[0];
					end
				end
				OP_CHANGE: begin
					if (found) begin
						pull_some = 1'b1;
						hold_load = 1'b1;
						count_d   = count_q - 1'b1;
						state_d   = ST_PLACE;
					end else begin
						res_load   = 1'b1;
						res_status = STS_NOT_FOUND;
					end
				end
				default: begin
					res_load = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			arrival_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			arrival_q <= arrival_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hold_load) begin
			hold_val_q   <= item_value;
			hold_pri_q   <= item_priority;
			hold_stamp_q <= first_stamp;
		end
		if (res_load) begin
			status_q  <= res_status;
			head_q    <= res_head;
			cnt_out_q <= count_d;
		end
	end

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		cell_cmd_t cmd;
		logic      left_gt;

		assign c_valid[k] = (CNT_W'(k) < count_q);
		assign cmd.ins    = ins_all;
		assign cmd.pull   = pull_all || (pull_some && from_first[k]);

		if (k == 0) begin : g_head
			assign left_gt = 1'b0;
		end else begin : g_body
			assign left_gt = c_gt[k-1];
		end

		// end cells take the broadcast entry as the missing neighbour; it is never kept valid
		spq_cell #(
			.STAMP_BITS(STAMP_BITS)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.valid      (c_valid[k]),
			.left_gt    (left_gt),
			.left_val   ((k == 0) ? new_val : c_val[(k == 0) ? 0 : k-1]),
			.left_pri   ((k == 0) ? new_pri : c_pri[(k == 0) ? 0 : k-1]),
			.left_stamp ((k == 0) ? new_stamp : c_stamp[(k == 0) ? 0 : k-1]),
			.right_val  ((k == CAPACITY-1) ? new_val :
			             c_val[(k == CAPACITY-1) ? k : k+1]),
			.right_pri  ((k == CAPACITY-1) ? new_pri :
			             c_pri[(k == CAPACITY-1) ? k : k+1]),
			.right_stamp((k == CAPACITY-1) ? new_stamp :
			             c_stamp[(k == CAPACITY-1) ? k : k+1]),
			.new_val    (new_val),
			.new_pri    (new_pri),
			.new_stamp  (new_stamp),
			.val        (c_val[k]),
			.pri        (c_pri[k]),
			.stamp      (c_stamp[k]),
			.gt         (c_gt[k]),
			.match      (c_match[k])
		);
	end

	spq_pick #(
		.CAPACITY  (CAPACITY),
		.STAMP_BITS(STAMP_BITS)
	) u_pick (
		.match      (c_match),
		.stamps     (c_stamp),
		.found      (found),
		.from_first (from_first),
		.first_stamp(first_stamp)
	);

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign head_value  = head_q;
	assign entry_count = cnt_out_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_place_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PLACE) |-> !out_valid_q)
		else $error("result pending while re-placing an entry");

	a_place_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PLACE) |=> (state_q == ST_IDLE) && out_valid_q)
		else $error("re-place step did not finish in one cycle");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == STS_FULL)) |-> (cnt_out_q == CNT_W'(CAPACITY)))
		else $error("full reported below capacity");
`endif

endmodule

>>> rtl/core/spq_cell.sv
module spq_cell #(
	parameter int STAMP_BITS = spq_pkg::STAMP_BITS_DEF
) (
	input  logic                             clk,
	input  spq_pkg::cell_cmd_t               cmd,
	input  logic                             valid,
	input  logic                             left_gt,
	input  logic        [spq_pkg::VAL_W-1:0] left_val,
	input  logic signed [spq_pkg::PRI_W-1:0] left_pri,
	input  logic        [STAMP_BITS-1:0]     left_stamp,
	input  logic        [spq_pkg::VAL_W-1:0] right_val,
	input  logic signed [spq_pkg::PRI_W-1:0] right_pri,
	input  logic        [STAMP_BITS-1:0]     right_stamp,
	input  logic        [spq_pkg::VAL_W-1:0] new_val,
	input  logic signed [spq_pkg::PRI_W-1:0] new_pri,
	input  logic        [STAMP_BITS-1:0]     new_stamp,
	output logic        [spq_pkg::VAL_W-1:0] val,
	output logic signed [spq_pkg::PRI_W-1:0] pri,
	output logic        [STAMP_BITS-1:0]     stamp,
	output logic                             gt,
	output logic                             match
);
	import spq_pkg::*;

	logic        [VAL_W-1:0]      val_q;
	logic signed [PRI_W-1:0]      pri_q;
	logic        [STAMP_BITS-1:0] stamp_q;

	// an empty cell always ranks below the broadcast entry
	assign gt    = !valid || (new_pri > pri_q) || ((new_pri == pri_q) && (new_stamp < stamp_q));
	assign match = valid && (val_q == new_val);

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (left_gt) begin
				val_q   <= left_val;
				pri_q   <= left_pri;
				stamp_q <= left_stamp;
			end else if (gt) begin
				val_q   <= new_val;
				pri_q   <= new_pri;
				stamp_q <= new_stamp;
			end
		end else if (cmd.pull) begin
			val_q   <= right_val;
			pri_q   <= right_pri;
			stamp_q <= right_stamp;
		end
	end

	assign val   = val_q;
	assign pri   = pri_q;
	assign stamp = stamp_q;

endmodule

>>> rtl/core/spq_pick.sv
module spq_pick #(
	parameter int CAPACITY   = spq_pkg::CAPACITY_DEF,
	parameter int STAMP_BITS = spq_pkg::STAMP_BITS_DEF
) (
	input  logic [CAPACITY-1:0]   match,
	input  logic [STAMP_BITS-1:0] stamps [CAPACITY],
	output logic                  found,
	output logic [CAPACITY-1:0]   from_first,
	output logic [STAMP_BITS-1:0] first_stamp
);
	logic [CAPACITY-1:0] first;

	// isolate lowest set bit, then mask it and everything above
	assign first      = match & (~match + {{(CAPACITY-1){1'b0}}, 1'b1});
	assign from_first = ~(first - {{(CAPACITY-1){1'b0}}, 1'b1});
	assign found      = |match;

	always_comb begin
		first_stamp = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			first_stamp = first_stamp | ({STAMP_BITS{first[k]}} & stamps[k]);
		end
	end

endmodule
